// ----- rtl/core/dsegscan_pkg.sv -----
// ----------------------------------------------------------------------------
// Decimal seven-segment scanner package
// Shared types, command codes and the segment pattern table.
// ----------------------------------------------------------------------------
package dsegscan_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM
  } scan_state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_DABBLE,
    CELL_SHIFT
  } cell_mode_t;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam int VALUE_W   = 32;
  localparam int BIT_CNT_W = 5;

  localparam logic [BIT_CNT_W-1:0] BIT_CNT_LAST = 5'd31;
  localparam logic [7:0]           SEL_NONE     = 8'hFF;

  function automatic logic [7:0] seg_pattern(input logic [3:0] d);
    logic [7:0] p;
    unique case (d)
      4'd0:    p = 8'h3F;
      4'd1:    p = 8'h06;
      4'd2:    p = 8'h5B;
      4'd3:    p = 8'h4F;
      4'd4:    p = 8'h66;
      4'd5:    p = 8'h6D;
      4'd6:    p = 8'h7D;
      4'd7:    p = 8'h07;
      4'd8:    p = 8'h7F;
      4'd9:    p = 8'h6F;
      default: p = 8'h3F;
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/core/dsegscan_cell.sv -----
// ----------------------------------------------------------------------------
// Decimal digit cell
// Holds one BCD digit; clears it, performs one shift-and-add-3 step or takes
// the digit of its lower neighbor.
// ----------------------------------------------------------------------------
module dsegscan_cell (
  input  logic                    clk,
  input  dsegscan_pkg::cell_mode_t mode,
  input  logic                    carry_in,
  input  logic [3:0]              digit_in,
  output logic [3:0]              digit,
  output logic                    carry_out
);
  import dsegscan_pkg::*;

  logic [3:0] adjusted;
  logic [3:0] digit_next;

  assign adjusted  = (digit >= 4'd5) ? 4'(digit + 4'd3) : digit;
  assign carry_out = adjusted[3];

  always_comb begin
    unique case (mode)
      CELL_CLEAR:  digit_next = 4'd0;
      CELL_DABBLE: digit_next = {adjusted[2:0], carry_in};
      CELL_SHIFT:  digit_next = digit_in;
      default:     digit_next = digit;
    endcase
  end

  always_ff @(posedge clk) begin
    digit <= digit_next;
  end

endmodule

// ----- rtl/core/decimal_seven_segment_scanner.sv -----
// ----------------------------------------------------------------------------
// Decimal seven-segment scanner
// Converts a loaded value to decimal digits in a chain of digit cells and
// emits one digit per scan tick, most significant first.
//
//   Channel | Direction | Signals
//   in      | sink      | in_valid, in_ready, command, value
//   out     | source    | out_valid, out_ready, digit_select, segments, last
//
// A tick's result appears in the output register in the cycle after the tick
// is taken. A load of a non-negative value occupies the block for 32
// shift-and-add-3 steps through the cell chain, then one shift per leading
// zero digit to align the number to the top cell.
// A pending result in the output register stalls the input side.
// Reset clears the digit count and scan slot, so nothing is shown.
// ----------------------------------------------------------------------------
module decimal_seven_segment_scanner #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                command,
  input  logic signed [dsegscan_pkg::VALUE_W-1:0] value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          digit_select,
  output logic [7:0]                          segments,
  output logic                                last
);
  import dsegscan_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  scan_state_t            state;
  scan_state_t            state_next;
  cell_mode_t             cell_mode;
  logic [CNT_W-1:0]       digit_count;
  logic [CNT_W-1:0]       scan_slot;
  logic                   ovf;
  logic [VALUE_W-1:0]     val_sr;
  logic [BIT_CNT_W-1:0]   bit_cnt;

  logic [3:0]             cell_digit [MAX_DIGITS];
  logic [MAX_DIGITS:0]    carry;
  logic [3:0]             top_digit;

  logic                   load_take;
  logic                   load_pos;
  logic                   tick_take;
  logic                   norm_move;
  logic                   is_last;
  logic [CNT_W-1:0]       rd_full;
  logic [IDX_W-1:0]       rd_idx;
  logic [3:0]             cur_digit;
  logic [7:0]             sel_next;

  assign carry[0] = val_sr[VALUE_W-1];

  for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_cell
    logic [3:0] lower_digit;
    if (k == 0) begin : g_first
      assign lower_digit = 4'd0;
    end else begin : g_rest
      assign lower_digit = cell_digit[k-1];
    end
    dsegscan_cell u_cell (
      .clk       (clk),
      .mode      (cell_mode),
      .carry_in  (carry[k]),
      .digit_in  (lower_digit),
      .digit     (cell_digit[k]),
      .carry_out (carry[k+1])
    );
  end

  assign top_digit = cell_digit[MAX_DIGITS-1];

  assign in_ready  = (state == ST_IDLE) && (!out_valid || out_ready);
  assign load_take = in_valid && in_ready && (command == CMD_LOAD);
  assign load_pos  = !value[VALUE_W-1];
  assign tick_take = in_valid && in_ready && (command == CMD_TICK) && (digit_count != '0);
  assign norm_move = (digit_count != '0) && (top_digit == 4'd0) && !ovf;

  assign is_last   = (scan_slot + CNT_W'(1)) == digit_count;
  assign rd_full   = CNT_W'(MAX_DIGITS - 1) - scan_slot;
  assign rd_idx    = rd_full[IDX_W-1:0];
  assign cur_digit = cell_digit[rd_idx];
  assign sel_next  = (scan_slot < 8) ? 8'(~(8'd1 << scan_slot)) : SEL_NONE;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (load_take && load_pos) state_next = ST_CONV;
      end
      ST_CONV: begin
        if (bit_cnt == BIT_CNT_LAST) state_next = ST_NORM;
      end
      ST_NORM: begin
        if (!norm_move) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cell_mode = CELL_HOLD;
    unique case (state)
      ST_IDLE: begin
        if (load_take && load_pos) cell_mode = CELL_CLEAR;
      end
      ST_CONV: cell_mode = CELL_DABBLE;
      ST_NORM: begin
        if (norm_move) cell_mode = CELL_SHIFT;
      end
      default: cell_mode = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      digit_count <= '0;
      scan_slot   <= '0;
      ovf         <= 1'b0;
      bit_cnt     <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (tick_take) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (load_take) begin
            scan_slot   <= '0;
            digit_count <= load_pos ? CNT_W'(MAX_DIGITS) : '0;
            ovf         <= 1'b0;
            bit_cnt     <= '0;
          end else if (tick_take) begin
            scan_slot <= is_last ? '0 : scan_slot + CNT_W'(1);
          end
        end
        ST_CONV: begin
          bit_cnt <= bit_cnt + BIT_CNT_W'(1);
          if (carry[MAX_DIGITS]) ovf <= 1'b1;
        end
        ST_NORM: begin
          if (norm_move) digit_count <= digit_count - CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_take) begin
      val_sr <= value;
    end else if (state == ST_CONV) begin
      val_sr <= {val_sr[VALUE_W-2:0], 1'b0};
    end
    if (tick_take) begin
      digit_select <= sel_next;
      segments     <= seg_pattern(cur_digit);
      last         <= is_last;
    end
  end

  // The output register only ever holds a digit of a nonempty scan.
  a_out_has_digits: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (digit_count != '0))
    else $error("result pending with an empty digit store");

  // The scan slot always points inside the stored digits.
  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    (digit_count != '0) |-> (scan_slot < digit_count))
    else $error("scan slot beyond digit count");

  // Conversion runs exactly one step per input bit.
  a_conv_length: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV && bit_cnt == '0) |-> ##32 (state == ST_NORM))
    else $error("conversion length wrong");

  // After alignment the top cell holds a nonzero leading digit.
  a_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && $past(state) == ST_NORM && digit_count != '0 && !ovf)
      |-> (top_digit != 4'd0))
    else $error("leading digit is zero after alignment");

endmodule
